FILE: src/pffs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_pkg
// Shared types, constants and the CRC byte update of the position fix frame
// serializer.
// ----------------------------------------------------------------------------
package pffs_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES   = 32;
  localparam int PAYLOAD_BYTES = 28;
  localparam int POS_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  // Frame offsets that carry something other than a stored payload byte.
  localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 5'd0;
  localparam logic [POS_W-1:0] POS_SYNC_SECOND = 5'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD_LO  = 5'd2;
  localparam logic [POS_W-1:0] POS_PAYLOAD_HI  = 5'd29;
  localparam logic [POS_W-1:0] POS_CRC_HIGH    = 5'd30;
  localparam logic [POS_W-1:0] POS_CRC_LOW     = 5'd31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_KIND   = 2'd3;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One fix record on the input channel.
  typedef struct packed {
    logic [7:0]         sequence_req;
    logic [31:0]        epoch_seconds;
    logic [31:0]        utc_time_code;
    logic signed [31:0] lat_value;
    logic signed [31:0] lon_value;
    logic signed [15:0] altitude_value;
    logic [7:0]         quality_code;
    logic [7:0]         satellite_count;
    logic [7:0]         dilution_value;
    logic [15:0]        heading_value;
    logic [15:0]        ground_speed;
  } in_item_t;

  // One frame byte on the output channel.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             capture;
    logic             emit;
    logic [POS_W-1:0] pos;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_room;
  } dp_status_t;

  // Feed one byte into the CRC, most significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: src/pffs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_if
// Valid/ready channels for fix records in and frame bytes out.
// ----------------------------------------------------------------------------
interface pffs_in_if;
  logic               valid;
  logic               ready;
  pffs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pffs_out_if;
  logic                valid;
  logic                ready;
  pffs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/position_fix_frame_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_fix_frame_serializer
// Turns one navigation fix record into a 32-byte frame with sync bytes,
// header, payload and a CRC-16/CCITT-FALSE, sent most significant byte first.
// ----------------------------------------------------------------------------
//   channel  direction  word
//   in_ch    sink       one fix record (in_item_t)
//   out_ch   source     one frame byte with end flag (out_item_t)
//   cfg_*    write      sync bytes, version and message type
//
// A record is taken only when no frame is in progress; its 32 bytes then leave
// one per cycle while out_ch takes them, and the next record can be taken in the
// cycle after the last byte is loaded into the output register, paced by the
// sequencer's offset counter.
// Backpressure on out_ch holds the sequencer; the output register keeps the
// last byte while the next record is accepted.
// Reset (rst_n low, synchronous) clears the configuration registers to zero.
module position_fix_frame_serializer (
  input  logic                            clk,
  input  logic                            rst_n,
  pffs_in_if.sink                         in_ch,
  pffs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pffs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pffs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pffs_pkg::dp_cmd_t    cmd;
  pffs_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  pffs_pkg::out_item_t  out_item;

  pffs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pffs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  // A record starts a frame, so no second record is taken right after it.
  a_one_frame_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("record accepted while a frame was starting");

  // Emitting the last offset loads a frame end flag into the output register.
  a_end_flag_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.pos == pffs_pkg::POS_CRC_LOW)) |=>
      (out_ch.valid && out_ch.data.frame_end))
    else $error("frame end flag missing after the last byte");

  // Emitting any other offset never raises the frame end flag.
  a_no_early_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.pos != pffs_pkg::POS_CRC_LOW)) |=> !out_ch.data.frame_end)
    else $error("frame end flag raised before the last byte");

  // Bytes are emitted only while a frame is in progress.
  a_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_ch.ready)
    else $error("byte emitted while idle");

endmodule

FILE: src/pffs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_ctrl
// Frame sequencer: takes a fix record when idle and steps through the 32
// frame offsets, one per word the output register can take.
// ----------------------------------------------------------------------------
module pffs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pffs_pkg::dp_status_t status,
  output pffs_pkg::dp_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic                       state_r, state_nxt;
  logic [pffs_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       emit;

  // A new record is taken only between frames.
  assign in_ready = (state_r == ST_IDLE);
  assign emit     = (state_r == ST_SEND) && status.out_room;

  assign cmd.capture = in_valid && in_ready;
  assign cmd.emit    = emit;
  assign cmd.pos     = pos_r;

  // Next state and offset.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SEND;
          pos_nxt   = pffs_pkg::POS_SYNC_FIRST;
        end
      end
      ST_SEND: begin
        if (emit) begin
          pos_nxt = pos_r + 1'b1;
          if (pos_r == pffs_pkg::POS_CRC_LOW) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

FILE: src/pffs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pffs_dpath
// Configuration registers, payload shift line, CRC accumulator and the
// output register.
// ----------------------------------------------------------------------------
module pffs_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pffs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pffs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  pffs_pkg::in_item_t              in_item,
  input  pffs_pkg::dp_cmd_t               cmd,
  output pffs_pkg::dp_status_t            status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pffs_pkg::out_item_t             out_item
);

  logic [7:0] sync_first_r, sync_second_r, format_version_r, message_kind_r;
  logic [7:0] pl_r [pffs_pkg::PAYLOAD_BYTES];
  logic [8*pffs_pkg::PAYLOAD_BYTES-1:0] pl_flat;
  logic [15:0] crc_r;
  logic        out_valid_r;
  pffs_pkg::out_item_t out_item_r;
  logic [7:0]  byte_sel;
  logic        in_payload;

  // Configuration writes; unknown indexes cannot occur with this index width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r     <= '0;
      sync_second_r    <= '0;
      format_version_r <= '0;
      message_kind_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pffs_pkg::CFG_SYNC_FIRST:     sync_first_r     <= cfg_wdata;
        pffs_pkg::CFG_SYNC_SECOND:    sync_second_r    <= cfg_wdata;
        pffs_pkg::CFG_FORMAT_VERSION: format_version_r <= cfg_wdata;
        pffs_pkg::CFG_MESSAGE_KIND:   message_kind_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Payload bytes of frame offsets 2 to 29, first byte in the top bits.
  assign pl_flat = {format_version_r, message_kind_r, in_item.sequence_req,
                    in_item.epoch_seconds, in_item.utc_time_code,
                    in_item.lat_value, in_item.lon_value, in_item.altitude_value,
                    in_item.quality_code, in_item.satellite_count,
                    in_item.dilution_value, in_item.heading_value,
                    in_item.ground_speed};

  assign in_payload = (cmd.pos >= pffs_pkg::POS_PAYLOAD_LO) &&
                      (cmd.pos <= pffs_pkg::POS_PAYLOAD_HI);

  // Shift line: entry 0 always holds the next payload byte to send.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < pffs_pkg::PAYLOAD_BYTES; i++) begin
        pl_r[i] <= pl_flat[8*(pffs_pkg::PAYLOAD_BYTES-1-i) +: 8];
      end
    end else if (cmd.emit && in_payload) begin
      for (int i = 0; i < pffs_pkg::PAYLOAD_BYTES - 1; i++) begin
        pl_r[i] <= pl_r[i+1];
      end
    end
  end

  // CRC runs over the payload bytes as they leave the shift line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= pffs_pkg::CRC_SEED;
    end else if (cmd.capture) begin
      crc_r <= pffs_pkg::CRC_SEED;
    end else if (cmd.emit && in_payload) begin
      crc_r <= pffs_pkg::crc_feed(crc_r, pl_r[0]);
    end
  end

  // Byte for the current frame offset.
  always_comb begin
    case (cmd.pos)
      pffs_pkg::POS_SYNC_FIRST:  byte_sel = sync_first_r;
      pffs_pkg::POS_SYNC_SECOND: byte_sel = sync_second_r;
      pffs_pkg::POS_CRC_HIGH:    byte_sel = crc_r[15:8];
      pffs_pkg::POS_CRC_LOW:     byte_sel = crc_r[7:0];
      default:                   byte_sel = pl_r[0];
    endcase
  end

  // Output register decouples the sequencer from the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.frame_byte <= byte_sel;
      out_item_r.frame_end  <= (cmd.pos == pffs_pkg::POS_CRC_LOW);
    end
  end

  assign status.out_room = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

endmodule
